// File: src/wcp_pkg.sv
// Shared types, register indexes and constants of the window co-occurrence pair generator.
// No dependencies; imported by window_cooccurrence_pairs_top and its bench.
`timescale 1ns / 1ps
package wcp_pkg;

  // Sizes
  localparam int WINDOW_MAX = 16;
  localparam int PTR_W      = 4;   // ring slot index
  localparam int CNT_W      = 5;   // window length register (0..31), count and distance (0..16)
  localparam int IDX_W      = 21;  // signed matrix index, all ones = none
  localparam int WIDX_W     = 20;  // vocabulary index on the input
  localparam int LAYER_W    = 4;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 3;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t IDX_NONE = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKWARD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_MARKER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_INDEX = 3'd6;

  // Pairing modes
  localparam logic [1:0] MODE_NEIGHBOR = 2'd0;
  localparam logic [1:0] MODE_BAG      = 2'd1;
  localparam logic [1:0] MODE_POS      = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  // floor(65536 / d) for distances 1..16
  function automatic logic [WEIGHT_W-1:0] bag_weight(input logic [CNT_W-1:0] d);
    logic [WEIGHT_W-1:0] r;
    case (d)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21845;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13107;
      5'd6:    r = 17'd10922;
      5'd7:    r = 17'd9362;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7281;
      5'd10:   r = 17'd6553;
      5'd11:   r = 17'd5957;
      5'd12:   r = 17'd5461;
      5'd13:   r = 17'd5041;
      5'd14:   r = 17'd4681;
      5'd15:   r = 17'd4369;
      5'd16:   r = 17'd4096;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/wcp_ring.sv
// Generic RAM: one write port and one registered read port, width and depth set per instance.
// No dependencies. Contents are undefined until written.
`timescale 1ns / 1ps
module wcp_ring #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a same-address write returns the old data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/window_cooccurrence_pairs_top.sv
// Top level of the window co-occurrence pair generator: sequencer, config and output register.
// Depends on wcp_pkg and wcp_ring.
`timescale 1ns / 1ps
// Takes word indices and end-of-sentence beats and emits co-occurrence increments
// (row, col, layer, weight) against the last W words of the sentence, nearest word
// first (in neighbor mode only the word W back), with m_tlast on the final increment
// of each input beat. One input beat is handled at a time: the wrap state, then the
// emit loop for its increments (up to 2*W, one per cycle through the emit loop and
// output register while m_tready is high), then the update state. The wrap state
// first brings the ring pointer back into range if the window was shrunk mid-sentence.
// An end beat with end_marker of -1 causes no increment and skips emit and update.
// Configuration must be written only while the block is idle; it is not enforced.
module window_cooccurrence_pairs_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] word_index, zero fill above
  input  logic [1:0]  s_tuser,   // [0] command, [1] known
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [20:0] row_index, [41:21] col_index, [45:42] layer,
                                 // [62:46] weight, zero fill above
  output logic        m_tlast,   // last
  // configuration
  input  logic        cfg_we,
  input  logic [wcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wcp_pkg::IDX_W-1:0]     cfg_data
);
  import wcp_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0] window_length;
  logic [1:0]       mode;
  logic             backward;
  logic             symmetric;
  idx_t             begin_marker;
  idx_t             end_marker;
  idx_t             unknown_index;

  // Sequencer state
  state_t           state, state_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] seen, seen_next;
  logic             in_sentence, in_sentence_next;
  idx_t             cur, cur_next;
  logic             skip, skip_next;
  logic [CNT_W-1:0] npairs, npairs_next;
  logic [CNT_W-1:0] d, d_next;
  logic [PTR_W-1:0] slot, slot_next;
  logic             swap, swap_next;

  // Ring port
  logic             ring_we;
  logic [PTR_W-1:0] ring_waddr;
  idx_t             ring_wdata;
  idx_t             past;

  // Helpers
  logic [CNT_W-1:0] w_eff;
  logic             accept;
  logic [PTR_W-1:0] start_ptr;
  logic [CNT_W-1:0] start_seen;
  logic [PTR_W-1:0] slot_prev;
  logic [CNT_W-1:0] d_minus1;
  logic             beat_load;
  logic             beat_final;
  idx_t             pair_row, pair_col, beat_row, beat_col;
  logic [LAYER_W-1:0]  beat_layer;
  logic [WEIGHT_W-1:0] beat_weight;

  // Window in use: zero counts as one, clamp to the ring depth
  always_comb begin
    if (window_length == '0) begin
      w_eff = CNT_W'(1);
    end else if (window_length > CNT_W'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = window_length;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Pointer and count at the start of an item, sentence start applied
  always_comb begin
    if (!in_sentence) begin
      if (begin_marker != IDX_NONE) begin
        start_seen = CNT_W'(1);
        start_ptr  = (w_eff == CNT_W'(1)) ? '0 : PTR_W'(1);
      end else begin
        start_seen = '0;
        start_ptr  = '0;
      end
    end else begin
      start_seen = seen;
      start_ptr  = ptr;
    end
  end

  // Next slot back, wrapping within the window
  assign slot_prev = (slot == '0) ? PTR_W'(w_eff - CNT_W'(1)) : slot - PTR_W'(1);
  assign d_minus1  = d - CNT_W'(1);

  // Output beat contents
  assign pair_row    = backward ? past : cur;
  assign pair_col    = backward ? cur : past;
  assign beat_row    = swap ? pair_col : pair_row;
  assign beat_col    = swap ? pair_row : pair_col;
  assign beat_layer  = (mode == MODE_POS) ? d_minus1[LAYER_W-1:0] : '0;
  assign beat_weight = (mode == MODE_BAG) ? bag_weight(d) : WEIGHT_ONE;
  assign beat_load   = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign beat_final  = (d == npairs) && (!symmetric || swap);

  // Sequencer: next state and ring writes
  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    seen_next        = seen;
    in_sentence_next = in_sentence;
    cur_next         = cur;
    skip_next        = skip;
    npairs_next      = npairs;
    d_next           = d;
    slot_next        = slot;
    swap_next        = swap;
    ring_we          = 1'b0;
    ring_waddr       = ptr;
    ring_wdata       = cur;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          // sentence start puts the begin marker in slot 0
          if (!in_sentence) begin
            ring_we    = 1'b1;
            ring_waddr = '0;
            ring_wdata = begin_marker;
          end
          ptr_next  = start_ptr;
          seen_next = (start_seen > w_eff) ? w_eff : start_seen;
          if (s_tuser[0]) begin
            in_sentence_next = 1'b0;
            cur_next         = end_marker;
            skip_next        = (end_marker == IDX_NONE);
          end else begin
            in_sentence_next = 1'b1;
            cur_next         = s_tuser[1] ? {1'b0, s_tdata[WIDX_W-1:0]} : unknown_index;
            skip_next        = 1'b0;
          end
          state_next = ST_WRAP;
        end
      end

      ST_WRAP: begin
        // bring the pointer into the window by repeated subtraction
        if ({1'b0, ptr} >= w_eff) begin
          ptr_next = PTR_W'({1'b0, ptr} - w_eff);
        end else begin
          d_next    = CNT_W'(1);
          swap_next = 1'b0;
          if (mode == MODE_NEIGHBOR) begin
            npairs_next = (seen >= w_eff) ? CNT_W'(1) : '0;
            slot_next   = ptr;
          end else if (mode == MODE_BAG || mode == MODE_POS) begin
            npairs_next = seen;
            slot_next   = (ptr == '0) ? PTR_W'(w_eff - CNT_W'(1)) : ptr - PTR_W'(1);
          end else begin
            npairs_next = '0;
            slot_next   = ptr;
          end
          if (skip) begin
            state_next = ST_IDLE;
          end else if (npairs_next == '0) begin
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (beat_load) begin
          if (symmetric && !swap) begin
            swap_next = 1'b1;
          end else begin
            swap_next = 1'b0;
            d_next    = d + CNT_W'(1);
            slot_next = slot_prev;
            if (d == npairs) begin
              state_next = ST_UPDATE;
            end
          end
        end
      end

      ST_UPDATE: begin
        // current word enters the ring
        ring_we    = 1'b1;
        ring_waddr = ptr;
        ring_wdata = cur;
        ptr_next   = (({1'b0, ptr} + CNT_W'(1)) == w_eff) ? '0 : ptr + PTR_W'(1);
        if (seen < w_eff) begin
          seen_next = seen + CNT_W'(1);
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ptr         <= '0;
      seen        <= '0;
      in_sentence <= 1'b0;
    end else begin
      state       <= state_next;
      ptr         <= ptr_next;
      seen        <= seen_next;
      in_sentence <= in_sentence_next;
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    skip   <= skip_next;
    npairs <= npairs_next;
    d      <= d_next;
    slot   <= slot_next;
    swap   <= swap_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CNT_W'(5);
      mode          <= MODE_NEIGHBOR;
      backward      <= 1'b0;
      symmetric     <= 1'b0;
      begin_marker  <= IDX_NONE;
      end_marker    <= IDX_NONE;
      unknown_index <= IDX_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[CNT_W-1:0];
        REG_MODE:          mode          <= cfg_data[1:0];
        REG_BACKWARD:      backward      <= cfg_data[0];
        REG_SYMMETRIC:     symmetric     <= cfg_data[0];
        REG_BEGIN_MARKER:  begin_marker  <= cfg_data;
        REG_END_MARKER:    end_marker    <= cfg_data;
        REG_UNKNOWN_INDEX: unknown_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (beat_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_load) begin
      m_tdata <= {1'b0, beat_weight, beat_layer, beat_col, beat_row};
      m_tlast <= beat_final;
    end
  end

  // Ring read address is the next slot, so the registered read data matches slot
  wcp_ring #(
    .WIDTH (IDX_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (slot_next),
    .rdata (past)
  );

`ifndef SYNTHESIS
  // Emit loop stays within the window and the pair count
  a_emit_in_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> ({1'b0, ptr} < w_eff) && ({1'b0, slot} < w_eff))
    else $error("ring pointer or slot outside the window while emitting");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (d != '0) && (d <= npairs))
    else $error("pair distance outside 1..count");

  // The final beat ends the emit loop and is shown with tlast
  a_final_beat: assert property (@(posedge clk) disable iff (rst)
    beat_load && beat_final |=> state == ST_UPDATE && m_tvalid && m_tlast)
    else $error("final beat did not close the item");

  // No new item while a previous one is still in the sequencer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_WRAP && !s_tready)
    else $error("item accepted while busy");
`endif

endmodule
